[rtl/core/qenc_pkg.sv]
// Shared types and constants for the quadrature encoder counter bank.
// Used by qenc_lane, qenc_merge and quad_encoder_counter_bank_unit.
package qenc_pkg;

    localparam int  PIN_W       = 4;
    localparam int  IDX_OUT_W   = 2;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_SNAPSHOT = 1'b1;

    localparam logic [7:0] STEP_WRAP_UP = 8'h00;
    localparam logic [7:0] STEP_WRAP_DN = 8'hFF;

    typedef struct packed {
        logic             opcode;
        logic [PIN_W-1:0] clock_levels;
        logic [PIN_W-1:0] data_levels;
    } t_in_req;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] encoder_index;
        logic                 direction_right;
        logic [7:0]           step_count;
        logic [7:0]           turn_count;
        logic signed [31:0]   running_total;
        logic                 last_of_run;
    } t_out_req;

    typedef struct packed {
        logic        dir_right;
        logic [7:0]  steps;
        logic [7:0]  turns;
        logic [31:0] total;
    } t_enc_state;

endpackage

[rtl/core/qenc_lane.sv]
// One encoder's counters: edge detect, step/turn counts and running total.
// Depends on qenc_pkg for the lane state struct.
module qenc_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sample,
    input  logic                i_clk_lvl,
    input  logic                i_dat_lvl,
    output qenc_pkg::t_enc_state o_state
);

    logic                 r_prev_clk;
    qenc_pkg::t_enc_state r_st;
    qenc_pkg::t_enc_state n_st;
    logic                 n_up;
    logic [7:0]           n_steps;

    always_comb begin
        n_st    = r_st;
        n_up    = i_clk_lvl ^ i_dat_lvl;
        n_steps = n_up ? (r_st.steps + 8'd1) : (r_st.steps - 8'd1);
        if (i_sample && (i_clk_lvl != r_prev_clk)) begin
            n_st.steps     = n_steps;
            n_st.dir_right = n_up;
            if (n_up) begin
                if (n_steps == qenc_pkg::STEP_WRAP_UP) begin
                    n_st.turns = r_st.turns + 8'd1;
                end
                n_st.total = r_st.total + {24'd0, n_steps};
            end else begin
                if (n_steps == qenc_pkg::STEP_WRAP_DN) begin
                    n_st.turns = r_st.turns - 8'd1;
                end
                n_st.total = r_st.total - {24'd0, n_steps};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_clk <= 1'b1;
            r_st       <= '0;
        end else begin
            if (i_sample) begin
                r_prev_clk <= i_clk_lvl;
            end
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

[rtl/core/qenc_merge.sv]
// Snapshot capture of all lanes and serialisation into report requests.
// Depends on qenc_pkg for lane state and output request types.
module qenc_merge #(
    parameter int NUM_ENCODERS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_snap_take,
    input  qenc_pkg::t_enc_state i_lane_st [NUM_ENCODERS],
    output logic                 o_busy,
    output logic                 o_valid,
    input  logic                 i_stall,
    output qenc_pkg::t_out_req   o_out
);

    localparam int IDX_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENCODERS - 1);

    qenc_pkg::t_enc_state r_snap [NUM_ENCODERS];
    qenc_pkg::t_out_req   r_out;
    logic                 r_busy;
    logic                 r_ovalid;
    logic [IDX_W-1:0]     r_idx;
    logic                 n_load;
    logic                 n_last;
    logic [IDX_W+1:0]     n_idx_ext;
    qenc_pkg::t_enc_state n_sel;

    assign n_load    = r_busy && (!r_ovalid || !i_stall);
    assign n_last    = (r_idx == LAST_IDX);
    assign n_idx_ext = {2'b00, r_idx};
    assign n_sel     = r_snap[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_snap_take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (n_load) begin
                r_idx <= r_idx + IDX_W'(1);
                if (n_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (n_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // frozen copy so samples may keep arriving while reports drain
    always_ff @(posedge i_clk) begin
        if (i_snap_take) begin
            r_snap <= i_lane_st;
        end
        if (n_load) begin
            r_out.encoder_index   <= n_idx_ext[1:0];
            r_out.direction_right <= n_sel.dir_right;
            r_out.step_count      <= n_sel.steps;
            r_out.turn_count      <= n_sel.turns;
            r_out.running_total   <= signed'(n_sel.total);
            r_out.last_of_run     <= n_last;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    a_take_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_take |=> (r_busy && (r_idx == '0)))
        else $error("snapshot take did not start a run at index zero");
    a_no_take_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_snap_take |-> !r_busy)
        else $error("snapshot taken while a run is still draining");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx <= LAST_IDX))
        else $error("report index beyond last encoder");
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_load && n_last && !i_snap_take) |=> (!r_busy && r_ovalid && r_out.last_of_run))
        else $error("last report did not close the run");
`endif

endmodule

[rtl/core/quad_encoder_counter_bank_unit.sv]
// Quadrature encoder counter bank: one counter lane per encoder, snapshot merge.
// Pin sample requests are taken every cycle and update all lanes together.
// A snapshot sets busy, then gives NUM_ENCODERS registered reports, one a cycle while
// i_stall is low; a further snapshot waits until the last report is loaded.
// Sync active-low reset clears all counters; previous clock levels reset to ones.
module quad_encoder_counter_bank_unit #(
    parameter int NUM_ENCODERS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  qenc_pkg::t_in_req  i_in,
    output logic               o_valid,
    input  logic               i_stall,
    output qenc_pkg::t_out_req o_out
);

    qenc_pkg::t_enc_state lane_st [NUM_ENCODERS];
    logic                 busy;
    logic                 accept;
    logic                 sample;
    logic                 snap_take;

    assign o_stall   = busy && (i_in.opcode == qenc_pkg::OP_SNAPSHOT);
    assign accept    = i_valid && !o_stall;
    assign sample    = accept && (i_in.opcode == qenc_pkg::OP_SAMPLE);
    assign snap_take = accept && (i_in.opcode == qenc_pkg::OP_SNAPSHOT);

    for (genvar e = 0; e < NUM_ENCODERS; e++) begin : g_lane
        logic clk_lvl;
        logic dat_lvl;
        // encoders past the pin fields see constant low levels
        if (e < qenc_pkg::PIN_W) begin : g_pin
            assign clk_lvl = i_in.clock_levels[e];
            assign dat_lvl = i_in.data_levels[e];
        end else begin : g_nopin
            assign clk_lvl = 1'b0;
            assign dat_lvl = 1'b0;
        end
        qenc_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_sample  (sample),
            .i_clk_lvl (clk_lvl),
            .i_dat_lvl (dat_lvl),
            .o_state   (lane_st[e])
        );
    end

    qenc_merge #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap_take (snap_take),
        .i_lane_st   (lane_st),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out)
    );

endmodule
